>>> rtl/core/bfp_pkg.sv
`default_nettype none

package bfp_pkg;

	localparam int BUFFER_BYTES  = 256;
	localparam int STORE_BYTES   = BUFFER_BYTES + 4;
	localparam int CAPACITY_BITS = BUFFER_BYTES * 8;

	localparam int BYTE_SHIFT = 3;
	localparam int NUM_BANKS  = 1 << BYTE_SHIFT;
	localparam int NUM_ROWS   = (STORE_BYTES + NUM_BANKS - 1) / NUM_BANKS;
	localparam int ROW_W      = $clog2(NUM_ROWS);

	localparam int POS_W  = 12;
	localparam int BADR_W = 9;
	localparam int LEN_W  = 6;
	localparam int VAL_W  = 31;
	localparam int WIN_W  = 40;

	typedef enum logic [2:0] {
		OP_APPEND = 3'd0,
		OP_SET    = 3'd1,
		OP_CLEAR  = 3'd2,
		OP_TEST   = 3'd3,
		OP_READ   = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MODIFY
	} state_t;

	// one accepted item, held while its bank reads are in flight
	typedef struct packed {
		logic [2:0]        opcode;
		logic [VAL_W-1:0]  value;
		logic [LEN_W-1:0]  len;
		logic [BADR_W-1:0] first;
		logic [2:0]        bitsel;
		logic [POS_W-1:0]  pos;
	} item_t;

	typedef struct packed {
		logic             ok;
		logic             bit_value;
		logic [7:0]       byte_value;
		logic [POS_W-1:0] bit_position;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/bfp_ram.sv
`default_nettype none

module bfp_ram #(
	parameter int DEPTH = 33,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/bfp_merge.sv
`default_nettype none

module bfp_merge import bfp_pkg::*; (
	input  wire item_t                           item,
	input  wire logic [NUM_BANKS-1:0][7:0]       rdata,
	output      logic [NUM_BANKS-1:0]            wr_en,
	output      logic [NUM_BANKS-1:0][7:0]       wr_data,
	output      result_t                         res
);

	logic [7:0]        win  [NUM_BANKS];
	logic [7:0]        newb [NUM_BANKS];
	logic [WIN_W-1:0]  window;
	logic [WIN_W-1:0]  merged;
	logic [VAL_W-1:0]  vmasked;
	logic [2:0]        offset;
	logic [5:0]        tail;
	logic [6:0]        span;
	logic [POS_W:0]    end_pos;
	logic              spill;
	logic              app_ok;
	logic              in_store;
	logic [7:0]        bmask;

	// gather the five-byte window starting at the item's first byte
	always_comb begin
		for (int i = 0; i < NUM_BANKS; i++) begin
			logic [BADR_W:0] a;
			a = {1'b0, item.first} + (BADR_W+1)'(i);
			if (i < 5 && a < (BADR_W+1)'(STORE_BYTES)) begin
				win[i] = rdata[a[2:0]];
			end else begin
				win[i] = 8'h00;
			end
		end
		window = {win[0], win[1], win[2], win[3], win[4]};
	end

	// keep bits ahead of the position, clear the rest, drop the field in
	always_comb begin
		offset  = item.pos[2:0];
		span    = 7'(offset) + 7'(item.len);
		spill   = span > 7'd32;
		end_pos = {1'b0, item.pos} + (POS_W+1)'(item.len);
		app_ok  = !item.len[5] && end_pos <= (POS_W+1)'(CAPACITY_BITS);
		vmasked = item.value & ({VAL_W{1'b1}} >> (5'd31 - item.len[4:0]));
		tail    = 6'(WIN_W) - 6'(offset) - 6'(item.len[4:0]);
		merged  = (window & ~({WIN_W{1'b1}} >> offset))
			| ({{(WIN_W-VAL_W){1'b0}}, vmasked} << tail);
		for (int i = 0; i < NUM_BANKS; i++) begin
			if (i < 5) begin
				newb[i] = merged[WIN_W-1-8*i -: 8];
			end else begin
				newb[i] = 8'h00;
			end
		end
	end

	assign in_store = {1'b0, item.first} < (BADR_W+1)'(STORE_BYTES);
	assign bmask    = 8'b1 << item.bitsel;

	// route window bytes back to their banks
	always_comb begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			logic [2:0]      i;
			logic [BADR_W:0] a;
			i = 3'(b) - item.first[2:0];
			a = {1'b0, item.first} + (BADR_W+1)'(i);
			wr_en[b]   = 1'b0;
			wr_data[b] = 8'h00;
			unique case (item.opcode)
				OP_APPEND: begin
					wr_en[b]   = app_ok && (i < 3'd4 || (i == 3'd4 && spill))
						&& a < (BADR_W+1)'(STORE_BYTES);
					wr_data[b] = newb[i];
				end
				OP_SET: begin
					wr_en[b]   = in_store && i == 3'd0;
					wr_data[b] = win[0] | bmask;
				end
				OP_CLEAR: begin
					wr_en[b]   = in_store && i == 3'd0;
					wr_data[b] = win[0] & ~bmask;
				end
				default: begin
					wr_en[b]   = 1'b0;
					wr_data[b] = 8'h00;
				end
			endcase
		end
	end

	always_comb begin
		res.ok           = 1'b1;
		res.bit_value    = 1'b0;
		res.byte_value   = 8'h00;
		res.bit_position = item.pos;
		unique case (item.opcode)
			OP_APPEND: begin
				res.ok = app_ok;
				if (app_ok) begin
					res.bit_position = end_pos[POS_W-1:0];
				end
			end
			OP_SET, OP_CLEAR: begin
				res.ok = 1'b1;
			end
			OP_TEST: begin
				res.bit_value = |(win[0] & bmask);
			end
			OP_READ: begin
				res.byte_value = win[0];
			end
			default: begin
				res.ok = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/bit_field_packer.sv
// A result is registered on the output port at commit, after its bank read.
// Transactions do not overlap: bank read, then merge and write back, then the next.
// A stalled output holds the merge step; the block then waits before writing.
// Reset: arst_n clears control and position at once, then a clearing pass zeroes
// the byte store, one row of all eight banks per cycle; in_ready stays low meanwhile.
`default_nettype none

module bit_field_packer import bfp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire logic [2:0]        opcode,
	input  wire logic [VAL_W-1:0]  field_value,
	input  wire logic [LEN_W-1:0]  field_len,
	input  wire logic [POS_W-1:0]  bit_index,
	input  wire logic [BADR_W-1:0] byte_addr,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      logic              ok,
	output      logic              bit_value,
	output      logic [7:0]        byte_value,
	output      logic [POS_W-1:0]  bit_position
);

	state_t state_q, state_d;

	logic [ROW_W-1:0]                  clr_row_q;
	logic [POS_W-1:0]                  write_pos_q;
	item_t                             item_s1;
	logic [NUM_BANKS-1:0][ROW_W-1:0]   rows_s1;
	logic [NUM_BANKS-1:0][ROW_W-1:0]   rd_rows;
	logic [NUM_BANKS-1:0][7:0]         rdata;
	logic [NUM_BANKS-1:0]              mg_wr_en;
	logic [NUM_BANKS-1:0][7:0]         mg_wr_data;
	logic [NUM_BANKS-1:0]              mem_we;
	logic [NUM_BANKS-1:0][ROW_W-1:0]   mem_waddr;
	logic [NUM_BANKS-1:0][7:0]         mem_wdata;
	logic                              accept;
	logic                              commit;
	logic [BADR_W-1:0]                 first;
	result_t                           res;

	logic              out_valid_q;
	logic              ok_q;
	logic              bit_value_q;
	logic [7:0]        byte_value_q;
	logic [POS_W-1:0]  bit_position_q;

	assign accept = in_valid && in_ready;
	// write back only once the output register can take the result
	assign commit = state_q == ST_MODIFY && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_row_q == ROW_W'(NUM_ROWS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_MODIFY;
				end
			end
			ST_MODIFY: begin
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// state outputs: input handshake and bank write port selection
	always_comb begin
		in_ready  = 1'b0;
		mem_we    = '0;
		mem_waddr = rows_s1;
		mem_wdata = mg_wr_data;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = '1;
				mem_waddr = {NUM_BANKS{clr_row_q}};
				mem_wdata = '0;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_MODIFY: begin
				if (commit) begin
					mem_we = mg_wr_en;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// first byte of the window: write position for append, else the addressed byte
	always_comb begin
		case (opcode)
			OP_APPEND:                 first = write_pos_q[POS_W-1:BYTE_SHIFT];
			OP_SET, OP_CLEAR, OP_TEST: first = bit_index[POS_W-1:BYTE_SHIFT];
			default:                   first = byte_addr;
		endcase
	end

	// each bank serves the one window byte that falls in it, on this row or the next
	always_comb begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			logic [2:0]      i;
			logic [BADR_W:0] a;
			i = 3'(b) - first[2:0];
			a = {1'b0, first} + (BADR_W+1)'(i);
			if (a[BADR_W:BYTE_SHIFT] < (BADR_W+1-BYTE_SHIFT)'(NUM_ROWS)) begin
				rd_rows[b] = ROW_W'(a[BADR_W:BYTE_SHIFT]);
			end else begin
				rd_rows[b] = '0;
			end
		end
	end

	for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
		bfp_ram #(
			.DEPTH(NUM_ROWS),
			.WIDTH(8)
		) u_ram (
			.clk  (clk),
			.we   (mem_we[g]),
			.waddr(mem_waddr[g]),
			.wdata(mem_wdata[g]),
			.re   (accept),
			.raddr(rd_rows[g]),
			.rdata(rdata[g])
		);
	end

	bfp_merge u_merge (
		.item   (item_s1),
		.rdata  (rdata),
		.wr_en  (mg_wr_en),
		.wr_data(mg_wr_data),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_row_q   <= '0;
			write_pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_row_q <= clr_row_q + ROW_W'(1);
			end
			if (commit) begin
				write_pos_q <= res.bit_position;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the item and its rows across the read cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.opcode <= opcode;
			item_s1.value  <= field_value;
			item_s1.len    <= field_len;
			item_s1.first  <= first;
			item_s1.bitsel <= bit_index[BYTE_SHIFT-1:0];
			item_s1.pos    <= write_pos_q;
			rows_s1        <= rd_rows;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			ok_q           <= res.ok;
			bit_value_q    <= res.bit_value;
			byte_value_q   <= res.byte_value;
			bit_position_q <= res.bit_position;
		end
	end

	assign out_valid    = out_valid_q;
	assign ok           = ok_q;
	assign bit_value    = bit_value_q;
	assign byte_value   = byte_value_q;
	assign bit_position = bit_position_q;

endmodule

`default_nettype wire

>>> rtl/core/bfp_checker.sv
`default_nettype none

module bfp_checker import bfp_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic             ok,
	input wire logic             bit_value,
	input wire logic [7:0]       byte_value,
	input wire logic [POS_W-1:0] bit_position
);

	// a stalled result holds its position
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bit_position))
		else $error("stalled result changed");

	// one transaction in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("back-to-back accept");

	// a refused operation reports no data
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> !bit_value && byte_value == 8'h00)
		else $error("data on refused operation");

	// position never runs past capacity
	a_pos_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bit_position <= POS_W'(CAPACITY_BITS))
		else $error("position past capacity");

	// bit test and byte read never both report
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bit_value |-> byte_value == 8'h00)
		else $error("bit and byte result together");

endmodule

bind bit_field_packer bfp_checker u_bfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.ok          (ok),
	.bit_value   (bit_value),
	.byte_value  (byte_value),
	.bit_position(bit_position)
);

`default_nettype wire

>>> dv/testbench.sv
module testbench;
	import bfp_pkg::*;

	// Opcodes the block does not define; they must come back with ok low
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

	localparam int STORE_BITS   = STORE_BYTES * 8;
	localparam int INDEX_MAX    = (1 << POS_W) - 1;
	localparam int ADDR_MAX     = (1 << BADR_W) - 1;
	localparam int STALL_LIMIT  = 2000;	// idle cycles before the run is declared hung
	localparam int LATENCY_WAIT = 10;	// settle time after the last result

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [2:0]        opcode = OP_APPEND;
	logic [VAL_W-1:0]  field_value = '0;
	logic [LEN_W-1:0]  field_len = '0;
	logic [POS_W-1:0]  bit_index = '0;
	logic [BADR_W-1:0] byte_addr = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              ok;
	logic              bit_value;
	logic [7:0]        byte_value;
	logic [POS_W-1:0]  bit_position;

	// Shadow copy of the byte store and the append position
	logic [7:0]  packed_bytes [STORE_BYTES];
	int unsigned write_pos;

	// Results owed by the block, oldest first
	result_t owed_results [$];

	int error_count = 0;
	int idle_cycles = 0;
	int ready_hold = 0;
	bit quiet_link = 1'b0;	// suppress idling on both sides while set

	bit_field_packer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.field_value  (field_value),
		.field_len    (field_len),
		.bit_index    (bit_index),
		.byte_addr    (byte_addr),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ok           (ok),
		.bit_value    (bit_value),
		.byte_value   (byte_value),
		.bit_position (bit_position)
	);

	always #5 clk = ~clk;

	task automatic report_error(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	// Idle stretch length: mostly short, now and then a long one
	function automatic int idle_span();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 30);
	endfunction

	// Apply one accepted transaction to the shadow store and return what the
	// block owes for it. Append works on a 32-bit window that starts at the
	// byte holding the position, or 40 bits when the field spills past it.
	function automatic result_t apply_packer_op(logic [2:0] op, logic [VAL_W-1:0] value,
			logic [LEN_W-1:0] len, logic [POS_W-1:0] idx, logic [BADR_W-1:0] addr);
		result_t     res;
		int unsigned byte_i, first, offset, wbytes, wbits, keep, tail, a;
		logic [7:0]  bit_mask;
		logic [63:0] window;
		logic [31:0] field_bits;

		res = '0;
		res.ok = 1'b1;
		byte_i = idx >> BYTE_SHIFT;
		bit_mask = 8'd1 << idx[2:0];
		case (op)
			OP_APPEND: begin
				if (len >= 32 || write_pos > CAPACITY_BITS || len > CAPACITY_BITS - write_pos) begin
					res.ok = 1'b0;
				end else begin
					first = write_pos >> BYTE_SHIFT;
					offset = write_pos & 7;
					wbytes = (offset + len > 32) ? 5 : 4;
					wbits = wbytes * 8;
					window = '0;
					for (int i = 0; i < wbytes; i++) begin
						a = first + i;
						window = (window << 8) | ((a < STORE_BYTES) ? packed_bytes[a] : 8'd0);
					end
					// keep bits ahead of the position, clear the rest, then merge the field
					keep = wbits - offset;
					tail = wbits - offset - len;
					window = (window >> keep) << keep;
					field_bits = {1'b0, value} & ((32'd1 << len) - 32'd1);
					window |= 64'(field_bits) << tail;
					for (int i = 0; i < wbytes; i++) begin
						a = first + i;
						if (a < STORE_BYTES)
							packed_bytes[a] = window[(wbytes - 1 - i) * 8 +: 8];
					end
					write_pos += len;
				end
			end
			OP_SET: begin
				if (byte_i < STORE_BYTES)
					packed_bytes[byte_i] |= bit_mask;
			end
			OP_CLEAR: begin
				if (byte_i < STORE_BYTES)
					packed_bytes[byte_i] &= ~bit_mask;
			end
			OP_TEST: begin
				if (byte_i < STORE_BYTES)
					res.bit_value = |(packed_bytes[byte_i] & bit_mask);
			end
			OP_READ: begin
				if (addr < STORE_BYTES)
					res.byte_value = packed_bytes[addr];
			end
			default: res.ok = 1'b0;
		endcase
		res.bit_position = write_pos[POS_W-1:0];
		return res;
	endfunction

	// Drive one transaction and hold it until accepted. Valid is left high on
	// return: the next call drops it or replaces the payload at the following falling edge,
	// or drain_results drops it.
	task automatic send_item(logic [2:0] op, logic [VAL_W-1:0] value, logic [LEN_W-1:0] len,
			logic [POS_W-1:0] idx, logic [BADR_W-1:0] addr);
		int gap;

		gap = (!quiet_link && $urandom_range(0, 99) < 40) ? idle_span() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		field_value <= value;
		field_len   <= len;
		bit_index   <= idx;
		byte_addr   <= addr;
		do @(posedge clk); while (!in_ready);
		owed_results.push_back(apply_packer_op(op, value, len, idx, addr));
	endtask

	// Drop valid and hold off until every owed result has come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	// One random transaction. Bit and byte addresses favor the area around the
	// append position, where appends and single-bit writes interact.
	task automatic send_random_item();
		int               r;
		int unsigned      lo, hi;
		logic [2:0]       op;
		logic [VAL_W-1:0] value;
		logic [LEN_W-1:0] len;
		logic [POS_W-1:0] idx;
		logic [BADR_W-1:0] addr;

		value = $urandom();
		len   = $urandom();
		if ($urandom_range(0, 15) == 0)
			value = '1;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			op  = OP_APPEND;
			len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 7) : $urandom_range(8, 31);
		end else if (r < 40) begin
			op = OP_SET;
		end else if (r < 55) begin
			op = OP_CLEAR;
		end else if (r < 73) begin
			op = OP_TEST;
		end else if (r < 93) begin
			op = OP_READ;
		end else if (r < 97) begin
			op  = OP_APPEND;
			len = $urandom_range(32, 63);
		end else begin
			op = $urandom_range(int'(OP_UNUSED_FIRST), int'(OP_UNUSED_LAST));
		end

		r = $urandom_range(0, 99);
		if (r < 10) begin
			idx = $urandom_range(STORE_BITS, INDEX_MAX);
		end else if (r < 45) begin
			lo  = (write_pos > 32) ? write_pos - 32 : 0;
			idx = $urandom_range(lo, write_pos + 8);
		end else begin
			idx = $urandom_range(0, STORE_BITS - 1);
		end

		r = $urandom_range(0, 99);
		if (r < 10) begin
			addr = $urandom_range(STORE_BYTES, ADDR_MAX);
		end else if (r < 40) begin
			lo   = ((write_pos >> 3) > 4) ? (write_pos >> 3) - 4 : 0;
			hi   = (write_pos >> 3) + 4;
			addr = $urandom_range(lo, (hi < STORE_BYTES) ? hi : STORE_BYTES - 1);
		end else begin
			addr = $urandom_range(0, STORE_BYTES - 1);
		end
		send_item(op, value, len, idx, addr);
	endtask

	// Store must come up all zero; unknown opcodes are refused
	task automatic test_reset_contents();
		send_item(OP_READ, '0, '0, '0, '0);
		send_item(OP_READ, '0, '0, '0, STORE_BYTES - 1);
		send_item(OP_TEST, '0, '0, STORE_BITS - 1, '0);
		for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
			send_item(op, '1, '1, '1, '1);
	endtask

	// Field extremes: empty field, full 31-bit field, value wider than its
	// length, a field that spills past the 32-bit window, over-long lengths,
	// and bit and byte addresses at and beyond the end of the store
	task automatic test_field_edges();
		send_item(OP_APPEND, '1, 6'd0, '0, '0);
		send_item(OP_APPEND, '1, 6'd31, '0, '0);
		send_item(OP_APPEND, '1, 6'd3, '0, '0);
		send_item(OP_APPEND, 31'h2AAA_AAAA, 6'd31, '0, '0);
		send_item(OP_APPEND, '1, 6'd32, '0, '0);
		send_item(OP_APPEND, '1, 6'd63, '0, '0);
		send_item(OP_READ, '0, '0, '0, 9'd4);
		send_item(OP_READ, '0, '0, '0, 9'd8);
		send_item(OP_SET, '0, '0, '0, '0);
		send_item(OP_SET, '0, '0, STORE_BITS - 1, '0);
		send_item(OP_SET, '0, '0, INDEX_MAX, '0);
		send_item(OP_TEST, '0, '0, STORE_BITS - 1, '0);
		send_item(OP_CLEAR, '0, '0, STORE_BITS - 1, '0);
		send_item(OP_TEST, '0, '0, STORE_BITS - 1, '0);
		send_item(OP_TEST, '0, '0, STORE_BITS, '0);
		send_item(OP_TEST, '0, '0, INDEX_MAX, '0);
		send_item(OP_TEST, '0, '0, '0, '0);
		send_item(OP_READ, '0, '0, '0, STORE_BYTES);
		send_item(OP_READ, '0, '0, '0, ADDR_MAX);
	endtask

	// Let the pipeline empty completely in the middle of traffic
	task automatic test_drain_pause();
		repeat (20) send_random_item();
		drain_results();
		repeat (20) send_random_item();
	endtask

	// Bulk random traffic, with one stretch at full rate on both sides
	task automatic test_random_traffic();
		for (int n = 0; n < 860; n++) begin
			quiet_link = (n >= 300 && n < 400);
			send_random_item();
		end
		quiet_link = 1'b0;
	endtask

	// Fill the stream to capacity, then hit the capacity check and the
	// empty append at the very end, which clears the slack bytes
	task automatic test_fill_to_capacity();
		int unsigned room;

		while (write_pos < CAPACITY_BITS) begin
			room = CAPACITY_BITS - write_pos;
			send_item(OP_APPEND, $urandom(), $urandom_range(1, (room < 31) ? room : 31), '0, '0);
			if ($urandom_range(0, 3) == 0)
				send_item(OP_READ, '0, '0, '0, write_pos >> 3);
		end
		send_item(OP_APPEND, '1, 6'd1, '0, '0);
		send_item(OP_APPEND, '1, 6'd31, '0, '0);
		send_item(OP_SET, '0, '0, STORE_BITS - 1, '0);
		send_item(OP_APPEND, '1, 6'd0, '0, '0);
		for (int a = BUFFER_BYTES - 1; a < STORE_BYTES; a++)
			send_item(OP_READ, '0, '0, '0, a);
		send_item(OP_TEST, '0, '0, CAPACITY_BITS - 1, '0);
	endtask

	// Result side: random back-pressure, ready bursts mixed with stalls
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (quiet_link || $urandom_range(0, 99) < 60) begin
			out_ready <= 1'b1;
			ready_hold = $urandom_range(1, 40);
		end else begin
			out_ready <= 1'b0;
			ready_hold = idle_span();
		end
	end

	// Compare every accepted result with the oldest one owed
	always @(posedge clk) begin
		result_t want;
		if (out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				report_error("result with no transaction outstanding");
			end else begin
				want = owed_results.pop_front();
				if (ok !== want.ok)
					report_error($sformatf("ok: got %0b expected %0b", ok, want.ok));
				if (bit_value !== want.bit_value)
					report_error($sformatf("bit_value: got %0b expected %0b",
						bit_value, want.bit_value));
				if (byte_value !== want.byte_value)
					report_error($sformatf("byte_value: got %0h expected %0h",
						byte_value, want.byte_value));
				if (bit_position !== want.bit_position)
					report_error($sformatf("bit_position: got %0d expected %0d",
						bit_position, want.bit_position));
			end
		end
	end

	// Hang detection: end the run after too long with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("bit_field_packer test failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < STORE_BYTES; i++)
			packed_bytes[i] = 8'd0;
		write_pos = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_contents();
		test_field_edges();
		test_drain_pause();
		test_random_traffic();
		test_fill_to_capacity();

		drain_results();
		repeat (LATENCY_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("bit_field_packer test passed");
		else
			$display("bit_field_packer test failed");
		$finish;
	end

endmodule

>>> bit_field_packer.f
rtl/core/bfp_pkg.sv
rtl/core/bfp_ram.sv
rtl/core/bfp_merge.sv
rtl/core/bit_field_packer.sv
rtl/core/bfp_checker.sv
dv/testbench.sv
